### hdl/bntd_pkg.sv
// ----------------------------------------------------------------------------
// bntd_pkg
// Shared types, constants and the alphabet lookup for the base-N text decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bntd_pkg;

   typedef enum logic [1:0] {
      ALPHA_BASE64    = 2'd0,
      ALPHA_BASE32HEX = 2'd1,
      ALPHA_HEX       = 2'd2,
      ALPHA_HEX_ALT   = 2'd3
   } alphabet_type;

   typedef enum logic [1:0] {
      CSR_ALPHABET     = 2'd0,
      CSR_GROUP_DIGITS = 2'd1,
      CSR_PAD_CODE     = 2'd2,
      CSR_PAD_LIMIT    = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_CHAR   = 3'd1,
      ST_PAD_MID    = 3'd2,
      ST_LEFTOVER   = 3'd3,
      ST_TOO_MANY   = 3'd4,
      ST_BAD_PAD    = 3'd5,
      ST_INCOMPLETE = 3'd6
   } status_type;

   localparam logic [7:0] SymWs  = 8'hEE;
   localparam logic [7:0] SymBad = 8'hFF;

   localparam logic [1:0] AlphabetReset    = 2'd0;
   localparam logic [3:0] GroupDigitsReset = 4'd4;
   localparam logic [7:0] PadCodeReset     = 8'd61;
   localparam logic [2:0] PadLimitReset    = 3'd2;
   localparam logic [3:0] GroupMax         = 4'd8;
   localparam logic [3:0] PadCountMax      = 4'd15;

   function automatic logic [7:0] lookup(input logic [1:0] sel, input logic [7:0] c);
      logic [7:0] v;
      v = SymBad;
      if (c inside {[8'h09:8'h0D], 8'h20}) begin
         v = SymWs;
      end else if (c inside {[8'h30:8'h39]}) begin
         v = (sel == ALPHA_BASE64) ? 8'(c - 8'h30 + 8'd52) : 8'(c - 8'h30);
      end else if (sel == ALPHA_BASE64) begin
         if (c inside {[8'h41:8'h5A]}) begin
            v = 8'(c - 8'h41);
         end else if (c inside {[8'h61:8'h7A]}) begin
            v = 8'(c - 8'h61 + 8'd26);
         end else if (c == 8'h2B) begin
            v = 8'd62;
         end else if (c == 8'h2F) begin
            v = 8'd63;
         end else if (c == 8'h3D) begin
            v = 8'd0;
         end
      end else if (sel == ALPHA_BASE32HEX) begin
         if (c inside {[8'h41:8'h56]}) begin
            v = 8'(c - 8'h41 + 8'd10);
         end else if (c inside {[8'h61:8'h76]}) begin
            v = 8'(c - 8'h61 + 8'd10);
         end
      end else begin
         if (c inside {[8'h41:8'h46]}) begin
            v = 8'(c - 8'h41 + 8'd10);
         end else if (c inside {[8'h61:8'h66]}) begin
            v = 8'(c - 8'h61 + 8'd10);
         end
      end
      return v;
   endfunction

endpackage

`default_nettype wire

### hdl/base_n_text_decoder.sv
// ----------------------------------------------------------------------------
// base_n_text_decoder
// Streaming base64 / base32hex / hex text decoder with end-of-string status.
// ----------------------------------------------------------------------------
// Each item is taken into an input register and decoded from there into
// the result register, so one character item is accepted every cycle while the
// result side keeps up; the rate is set by the single alphabet lookup and bit
// packing step between those two registers. A character item yields at most
// one data byte, and an end item always yields one status item and clears the
// decoding state.
`default_nettype none

module base_n_text_decoder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_command,
   input  wire logic [7:0] req_char_code,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_kind,
   output logic [7:0]      rsp_data_byte,
   output logic [2:0]      rsp_status,
   input  wire logic       csr_write_enable,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_write_data
);

   logic [1:0]  alphabet_ff;
   logic [3:0]  group_digits_ff;
   logic [7:0]  pad_code_ff;
   logic [2:0]  pad_limit_ff;

   logic        s1_valid_ff;
   logic        s1_command_ff;
   logic [7:0]  s1_char_ff;

   logic [6:0]  partial_ff, partial_in;
   logic [2:0]  bit_count_ff, bit_count_in;
   logic [2:0]  group_pos_ff, group_pos_in;
   logic [3:0]  pad_count_ff, pad_count_in;
   logic [2:0]  error_ff, error_in;

   logic        rsp_valid_ff;
   logic        rsp_kind_ff, rsp_kind_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic        emit;

   logic        advance;
   logic        step;
   logic [1:0]  sel;
   logic [2:0]  bpd;
   logic [3:0]  group_size;
   logic [2:0]  group_next;
   logic [7:0]  sym;
   logic [12:0] wide;
   logic [3:0]  total;
   logic [3:0]  spill;
   logic [6:0]  pad_bits;
   logic [6:0]  pad_round;
   logic [6:0]  pad_span;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step      = s1_valid_ff && advance;
   assign req_ready = !s1_valid_ff || advance;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_data_byte = rsp_data_ff;
   assign rsp_status    = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alphabet_ff     <= bntd_pkg::AlphabetReset;
         group_digits_ff <= bntd_pkg::GroupDigitsReset;
         pad_code_ff     <= bntd_pkg::PadCodeReset;
         pad_limit_ff    <= bntd_pkg::PadLimitReset;
      end else if (csr_write_enable) begin
         case (csr_index)
            bntd_pkg::CSR_ALPHABET:     alphabet_ff     <= csr_write_data[1:0];
            bntd_pkg::CSR_GROUP_DIGITS: group_digits_ff <= csr_write_data[3:0];
            bntd_pkg::CSR_PAD_CODE:     pad_code_ff     <= csr_write_data;
            bntd_pkg::CSR_PAD_LIMIT:    pad_limit_ff    <= csr_write_data[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_command_ff <= req_command;
         s1_char_ff    <= req_char_code;
      end
   end

   always_comb begin
      sel = (alphabet_ff == bntd_pkg::ALPHA_HEX_ALT) ? bntd_pkg::ALPHA_HEX : alphabet_ff;
      case (sel)
         bntd_pkg::ALPHA_BASE64:    bpd = 3'd6;
         bntd_pkg::ALPHA_BASE32HEX: bpd = 3'd5;
         default:                   bpd = 3'd4;
      endcase
      group_size = (group_digits_ff > bntd_pkg::GroupMax) ? bntd_pkg::GroupMax
                                                          : group_digits_ff;
      if (group_size == 4'd0) begin
         group_next = group_pos_ff;
      end else if (({1'b0, group_pos_ff} + 4'd1) >= group_size) begin
         group_next = 3'd0;
      end else begin
         group_next = group_pos_ff + 3'd1;
      end

      sym   = bntd_pkg::lookup(sel, s1_char_ff);
      wide  = (13'(partial_ff) << bpd) | 13'(sym[5:0]);
      total = {1'b0, bit_count_ff} + {1'b0, bpd};
      spill = total - 4'd8;

      pad_bits  = 7'(pad_count_ff) * 7'(bpd);
      pad_round = (pad_bits + 7'd7) & 7'h78;
      pad_span  = 7'(bpd) * (7'(pad_count_ff) + 7'd1);

      partial_in    = partial_ff;
      bit_count_in  = bit_count_ff;
      group_pos_in  = group_pos_ff;
      pad_count_in  = pad_count_ff;
      error_in      = error_ff;
      emit          = 1'b0;
      rsp_kind_in   = 1'b0;
      rsp_data_in   = 8'd0;
      rsp_status_in = bntd_pkg::ST_OK;

      if (s1_command_ff) begin
         emit        = 1'b1;
         rsp_kind_in = 1'b1;
         if (error_ff != 3'd0) begin
            rsp_status_in = error_ff;
         end else if (bit_count_ff != 3'd0 && partial_ff != 7'd0) begin
            rsp_status_in = bntd_pkg::ST_LEFTOVER;
         end else if (pad_code_ff != 8'd0 && pad_count_ff > {1'b0, pad_limit_ff}) begin
            rsp_status_in = bntd_pkg::ST_TOO_MANY;
         end else if (pad_code_ff != 8'd0 && pad_round > pad_span) begin
            rsp_status_in = bntd_pkg::ST_BAD_PAD;
         end else if (group_pos_ff != 3'd0) begin
            rsp_status_in = bntd_pkg::ST_INCOMPLETE;
         end
         partial_in   = 7'd0;
         bit_count_in = 3'd0;
         group_pos_in = 3'd0;
         pad_count_in = 4'd0;
         error_in     = 3'd0;
      end else if (error_ff != 3'd0) begin
         error_in = error_ff;
      end else if (pad_code_ff != 8'd0 && s1_char_ff == pad_code_ff) begin
         if (pad_count_ff < bntd_pkg::PadCountMax) begin
            pad_count_in = pad_count_ff + 4'd1;
         end
         group_pos_in = group_next;
      end else if (sym == bntd_pkg::SymWs) begin
         error_in = error_ff;
      end else if (sym == bntd_pkg::SymBad) begin
         error_in = bntd_pkg::ST_BAD_CHAR;
      end else if (pad_count_ff != 4'd0) begin
         error_in = bntd_pkg::ST_PAD_MID;
      end else begin
         group_pos_in = group_next;
         if (total >= 4'd8) begin
            emit         = 1'b1;
            rsp_data_in  = 8'(wide >> spill);
            partial_in   = 7'(wide & ((13'd1 << spill) - 13'd1));
            bit_count_in = spill[2:0];
         end else begin
            partial_in   = wide[6:0];
            bit_count_in = total[2:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff   <= 7'd0;
         bit_count_ff <= 3'd0;
         group_pos_ff <= 3'd0;
         pad_count_ff <= 4'd0;
         error_ff     <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= step && emit;
         if (step) begin
            partial_ff   <= partial_in;
            bit_count_ff <= bit_count_in;
            group_pos_ff <= group_pos_in;
            pad_count_ff <= pad_count_in;
            error_ff     <= error_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (step && s1_command_ff) |=> (error_ff == 3'd0 && pad_count_ff == 4'd0 &&
                                   bit_count_ff == 3'd0 && group_pos_ff == 3'd0))
      else $error("End item did not clear the decoding state.");

   a_status_zero_on_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_kind) |-> (rsp_status == bntd_pkg::ST_OK))
      else $error("Data item carries a nonzero status.");

   a_data_zero_on_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind) |-> (rsp_data_byte == 8'd0))
      else $error("End item carries a nonzero data byte.");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (step && !s1_command_ff && error_ff != 3'd0) |=> $stable(error_ff))
      else $error("Sticky error changed before the end item.");

endmodule

`default_nettype wire

### dv/bntd_decode_checker.sv
// ----------------------------------------------------------------------------
// bntd_decode_checker
// Watches both channels and the register port of the base-N text decoder. It
// decodes every accepted item on its own, queues the data bytes and end
// statuses that should come out, and compares each accepted result with the
// oldest queued one. Mismatches and results that nothing accounts for are
// counted and handed to the top.
// ----------------------------------------------------------------------------
module bntd_decode_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic       req_command,
   input  wire logic [7:0] req_char_code,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic       rsp_kind,
   input  wire logic [7:0] rsp_data_byte,
   input  wire logic [2:0] rsp_status,
   input  wire logic       csr_write_enable,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_write_data,
   output int              mismatch_count,
   output int              outputs_in_flight
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic KindData   = 1'b0;
   localparam logic KindStatus = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic [2:0] status;
   } decoded_type;

   decoded_type decoded_outputs[$];

   bntd_pkg::alphabet_type alpha_reg;
   logic [3:0]             group_reg;
   logic [7:0]             pad_reg;
   logic [2:0]             pad_limit_reg;

   logic [6:0]             acc_bits;
   logic [2:0]             acc_count;
   logic [2:0]             group_pos;
   logic [3:0]             pads_seen;
   bntd_pkg::status_type   sticky_err;

   function automatic logic [7:0] char_digit(input bntd_pkg::alphabet_type sel,
                                             input logic [7:0] c);
      if ((c >= 8'h09 && c <= 8'h0D) || c == 8'h20) begin
         return bntd_pkg::SymWs;
      end
      if (c >= "0" && c <= "9") begin
         return (sel == bntd_pkg::ALPHA_BASE64) ? 8'(c - "0" + 52) : 8'(c - "0");
      end
      if (sel == bntd_pkg::ALPHA_BASE64) begin
         if (c >= "A" && c <= "Z") return 8'(c - "A");
         if (c >= "a" && c <= "z") return 8'(c - "a" + 26);
         if (c == "+") return 8'd62;
         if (c == "/") return 8'd63;
         if (c == "=") return 8'd0;
         return bntd_pkg::SymBad;
      end
      if (sel == bntd_pkg::ALPHA_BASE32HEX) begin
         if (c >= "A" && c <= "V") return 8'(c - "A" + 10);
         if (c >= "a" && c <= "v") return 8'(c - "a" + 10);
         return bntd_pkg::SymBad;
      end
      if (c >= "A" && c <= "F") return 8'(c - "A" + 10);
      if (c >= "a" && c <= "f") return 8'(c - "a" + 10);
      return bntd_pkg::SymBad;
   endfunction

   function automatic void clear_decode();
      acc_bits   = '0;
      acc_count  = '0;
      group_pos  = '0;
      pads_seen  = '0;
      sticky_err = bntd_pkg::ST_OK;
   endfunction

   function automatic void emit(input logic kind, input logic [7:0] data,
                                input bntd_pkg::status_type st);
      decoded_type r;
      r.kind      = kind;
      r.data_byte = data;
      r.status    = st;
      decoded_outputs.insert(decoded_outputs.size(), r);
   endfunction

   function automatic void step_group();
      int g;
      int p;
      g = (group_reg > bntd_pkg::GroupMax) ? int'(bntd_pkg::GroupMax) : int'(group_reg);
      p = int'(group_pos) + 1;
      if (g != 0) begin
         group_pos = (p >= g) ? 3'd0 : 3'(p);
      end
   endfunction

   function automatic void decode_step(input logic is_end, input logic [7:0] c);
      bntd_pkg::alphabet_type sel;
      int                     bpd;
      int                     pc;
      int                     cnt;
      logic [7:0]             v;
      logic [7:0]             acc;
      bntd_pkg::status_type   st;
      sel = (alpha_reg == bntd_pkg::ALPHA_HEX_ALT) ? bntd_pkg::ALPHA_HEX : alpha_reg;
      bpd = (sel == bntd_pkg::ALPHA_BASE64) ? 6 : (sel == bntd_pkg::ALPHA_BASE32HEX) ? 5 : 4;
      pc  = int'(pads_seen);
      if (is_end) begin
         st = bntd_pkg::ST_OK;
         if (sticky_err != bntd_pkg::ST_OK) begin
            st = sticky_err;
         end else if (acc_count != 0 && acc_bits != 0) begin
            st = bntd_pkg::ST_LEFTOVER;
         end else if (pad_reg != 0 && pads_seen > pad_limit_reg) begin
            st = bntd_pkg::ST_TOO_MANY;
         end else if (pad_reg != 0 && (((pc * bpd) + 7) & ~7) > bpd * (pc + 1)) begin
            st = bntd_pkg::ST_BAD_PAD;
         end else if (group_pos != 0) begin
            st = bntd_pkg::ST_INCOMPLETE;
         end
         clear_decode();
         emit(KindStatus, 8'd0, st);
      end else if (sticky_err != bntd_pkg::ST_OK) begin
         // Everything up to the end item is ignored once an error is latched.
      end else if (pad_reg != 0 && c == pad_reg) begin
         if (pads_seen != bntd_pkg::PadCountMax) begin
            pads_seen = pads_seen + 4'd1;
         end
         step_group();
      end else begin
         v = char_digit(sel, c);
         if (v == bntd_pkg::SymBad) begin
            sticky_err = bntd_pkg::ST_BAD_CHAR;
         end else if (v != bntd_pkg::SymWs && pads_seen != 0) begin
            sticky_err = bntd_pkg::ST_PAD_MID;
         end else if (v != bntd_pkg::SymWs) begin
            step_group();
            acc = {1'b0, acc_bits};
            cnt = int'(acc_count);
            for (int i = bpd - 1; i >= 0; i--) begin
               acc = {acc[6:0], v[i]};
               cnt++;
               if (cnt == 8) begin
                  emit(KindData, acc, bntd_pkg::ST_OK);
                  acc = '0;
                  cnt = 0;
               end
            end
            acc_bits  = acc[6:0];
            acc_count = 3'(cnt);
         end
      end
   endfunction

   always @(posedge clock) begin : watch
      decoded_type oldest;
      if (reset) begin
         alpha_reg     = bntd_pkg::alphabet_type'(bntd_pkg::AlphabetReset);
         group_reg     = bntd_pkg::GroupDigitsReset;
         pad_reg       = bntd_pkg::PadCodeReset;
         pad_limit_reg = bntd_pkg::PadLimitReset;
         clear_decode();
         decoded_outputs.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (decoded_outputs.size() == 0) begin
               $error("result with nothing outstanding: kind %0d, data_byte %0h, status %0d",
                      rsp_kind, rsp_data_byte, rsp_status);
               mismatch_count++;
            end else begin
               oldest = decoded_outputs.pop_front();
               if (rsp_kind !== oldest.kind) begin
                  $error("kind mismatch: expected %0d, actual %0d", oldest.kind, rsp_kind);
                  mismatch_count++;
               end
               if (rsp_data_byte !== oldest.data_byte) begin
                  $error("data_byte mismatch: expected %0h, actual %0h",
                         oldest.data_byte, rsp_data_byte);
                  mismatch_count++;
               end
               if (rsp_status !== oldest.status) begin
                  $error("status mismatch: expected %0d, actual %0d", oldest.status, rsp_status);
                  mismatch_count++;
               end
            end
         end
         if (csr_write_enable) begin
            case (bntd_pkg::csr_index_type'(csr_index))
               bntd_pkg::CSR_ALPHABET:
                  alpha_reg = bntd_pkg::alphabet_type'(csr_write_data[1:0]);
               bntd_pkg::CSR_GROUP_DIGITS: group_reg = csr_write_data[3:0];
               bntd_pkg::CSR_PAD_CODE:     pad_reg = csr_write_data;
               bntd_pkg::CSR_PAD_LIMIT:    pad_limit_reg = csr_write_data[2:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            decode_step(req_command, req_char_code);
         end
      end
      outputs_in_flight = decoded_outputs.size();
   end

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the base-N text decoder with a short directed set of strings, a
// back-pressure burst, and then random strings under many register settings.
// Both channels idle at random. A checker beside the block predicts and
// compares every result; this module only makes traffic and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic CmdChar       = 1'b0;
   localparam logic CmdEnd        = 1'b1;
   localparam int   WatchdogLimit = 2000;
   localparam int   RandomItems   = 750;
   localparam int   PhaseCount    = 12;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_command = 1'b0;
   logic [7:0] req_char_code = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_kind;
   logic [7:0] rsp_data_byte;
   logic [2:0] rsp_status;
   logic       csr_write_enable = 1'b0;
   logic [1:0] csr_index = 2'd0;
   logic [7:0] csr_write_data = 8'd0;

   int                     mismatch_count;
   int                     outputs_in_flight;
   int                     items_sent = 0;
   int                     quiet_cycles = 0;
   bit                     gaps_on = 1'b1;
   bit                     hold_off_request = 1'b0;
   bit                     hold_active = 1'b0;
   bntd_pkg::alphabet_type cfg_alpha = bntd_pkg::ALPHA_BASE64;
   logic [3:0]             cfg_group = bntd_pkg::GroupDigitsReset;
   logic [7:0]             cfg_pad = bntd_pkg::PadCodeReset;
   logic [2:0]             cfg_pad_limit = bntd_pkg::PadLimitReset;

   always #5 clock = ~clock;

   base_n_text_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_char_code    (req_char_code),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   bntd_decode_checker decode_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_char_code     (req_char_code),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_status        (rsp_status),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .mismatch_count    (mismatch_count),
      .outputs_in_flight (outputs_in_flight)
   );

   function automatic int gap_length();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] digit_char(input int v);
      logic [7:0] d;
      if (cfg_alpha == bntd_pkg::ALPHA_BASE64) begin
         if (v < 26)      d = 8'(8'h41 + v);
         else if (v < 52) d = 8'(8'h61 + v - 26);
         else if (v < 62) d = 8'(8'h30 + v - 52);
         else if (v == 62) d = "+";
         else             d = "/";
      end else if (v < 10) begin
         d = 8'(8'h30 + v);
      end else begin
         d = 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10);
      end
      return d;
   endfunction

   function automatic logic [7:0] blank_char();
      return ($urandom_range(0, 5) == 5) ? 8'h20 : 8'(9 + $urandom_range(0, 4));
   endfunction

   task automatic send_item(input logic cmd, input logic [7:0] c);
      int gap;
      gap = (gaps_on && $urandom_range(0, 1)) ? gap_length() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_char_code <= c;
      do begin
         @(posedge clock);
      end while (!req_ready);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_item(CmdChar, s[i]);
      end
      send_item(CmdEnd, 8'($urandom_range(0, 255)));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outputs_in_flight != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic apply_config(input bntd_pkg::alphabet_type a, input logic [3:0] g,
                               input logic [7:0] p, input logic [2:0] l);
      cfg_alpha     = a;
      cfg_group     = g;
      cfg_pad       = p;
      cfg_pad_limit = l;
      csr_write_enable <= 1'b1;
      csr_index        <= bntd_pkg::CSR_ALPHABET;
      csr_write_data   <= {6'd0, a};
      @(posedge clock);
      csr_index      <= bntd_pkg::CSR_GROUP_DIGITS;
      csr_write_data <= {4'd0, g};
      @(posedge clock);
      csr_index      <= bntd_pkg::CSR_PAD_CODE;
      csr_write_data <= p;
      @(posedge clock);
      csr_index      <= bntd_pkg::CSR_PAD_LIMIT;
      csr_write_data <= {5'd0, l};
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_random_string();
      int mode;
      int bpd;
      int n_digits;
      int n_pads;
      int g;
      int lb;
      int v;
      mode = $urandom_range(0, 9);
      if (mode == 9) begin
         repeat ($urandom_range(1, 8)) begin
            send_item($urandom_range(0, 4) == 0 ? CmdEnd : CmdChar, 8'($urandom_range(0, 255)));
         end
      end else begin
         bpd = (cfg_alpha == bntd_pkg::ALPHA_BASE64) ? 6 :
               (cfg_alpha == bntd_pkg::ALPHA_BASE32HEX) ? 5 : 4;
         n_digits = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 9);
         for (int i = 0; i < n_digits; i++) begin
            if ($urandom_range(0, 19) == 0) begin
               send_item(CmdChar, blank_char());
            end
            if (mode >= 7 && $urandom_range(0, 7) == 0) begin
               send_item(CmdChar, 8'($urandom_range(0, 255)));
            end
            v = $urandom_range(0, (1 << bpd) - 1);
            if (i == n_digits - 1 && $urandom_range(0, 1)) begin
               lb = (n_digits * bpd) % 8;
               v  = (lb >= bpd) ? 0 : (v & ~((1 << lb) - 1));
            end
            send_item(CmdChar, digit_char(v));
         end
         g = (cfg_group > 8) ? 8 : int'(cfg_group);
         case ($urandom_range(0, 5))
            0, 1, 2: n_pads = (g != 0) ? (g - n_digits % g) % g : 0;
            3:       n_pads = $urandom_range(0, int'(cfg_pad_limit) + 1);
            4:       n_pads = 0;
            default: n_pads = ($urandom_range(0, 5) == 0) ? 17 : 1;
         endcase
         if (cfg_pad != 0) begin
            repeat (n_pads) send_item(CmdChar, cfg_pad);
         end
         if (mode >= 7 && $urandom_range(0, 1)) begin
            send_item(CmdChar, digit_char($urandom_range(0, (1 << bpd) - 1)));
         end
         send_item(CmdEnd, 8'($urandom_range(0, 255)));
      end
   endtask

   initial begin : receiver
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_active = 1'b1;
            rsp_ready <= 1'b0;
            repeat (80) @(posedge clock);
            hold_active = 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat (gap_length()) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WatchdogLimit) begin
         $display("** base_n_text_decoder: FAILED **");
         $finish;
      end
   end

   initial begin : stimulus
      int goal;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_text("+/9z");
      send_text("TQ==");
      send_text("T R");
      send_text("*A");
      send_text("=A");
      send_text("===");
      send_item(CmdChar, 8'hFF);
      send_item(CmdEnd, 8'h00);
      drain_results();

      // The receiver stops for a long stretch while items keep coming.
      gaps_on = 1'b0;
      hold_off_request = 1'b1;
      wait (hold_active);
      hold_off_request = 1'b0;
      @(posedge clock);
      send_text("TWFueSBjYXJuYWwgcGxlYXN1cmUu");
      drain_results();

      goal = items_sent;
      for (int phase = 0; phase < PhaseCount; phase++) begin
         drain_results();
         case (phase)
            0: apply_config(bntd_pkg::ALPHA_BASE32HEX, 4'd8, "=", 3'd6);
            1: apply_config(bntd_pkg::ALPHA_HEX, 4'd2, 8'd0, 3'd0);
            2: apply_config(bntd_pkg::ALPHA_HEX_ALT, 4'd15, "=", 3'd7);
            3: apply_config(bntd_pkg::ALPHA_BASE64, 4'd0, 8'd0, 3'd0);
            4: apply_config(bntd_pkg::ALPHA_BASE32HEX, 4'd1, 8'hFF, 3'd3);
            5: apply_config(bntd_pkg::ALPHA_BASE64, 4'd4, "=", 3'd2);
            default: apply_config(bntd_pkg::alphabet_type'($urandom_range(0, 3)),
                                  4'($urandom_range(0, 15)),
                                  $urandom_range(0, 1) ? "=" : 8'($urandom_range(0, 255)),
                                  3'($urandom_range(0, 7)));
         endcase
         gaps_on = (phase % 3 != 2);
         goal = goal + RandomItems / PhaseCount;
         while (items_sent < goal) send_random_string();
      end

      drain_results();
      repeat (12) @(posedge clock);
      if (mismatch_count == 0 && outputs_in_flight == 0) begin
         $display("** base_n_text_decoder: PASSED **");
      end else begin
         $display("** base_n_text_decoder: FAILED **");
      end
      $finish;
   end

endmodule

### sim.f
hdl/bntd_pkg.sv
hdl/base_n_text_decoder.sv
dv/bntd_decode_checker.sv
dv/tb_top.sv
